// File: hdl/substring_first_match_assert.svh
// Assertion shorthands used by the checker file.
`ifndef SUBSTRING_FIRST_MATCH_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SFM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("substring_first_match check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SFM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("substring_first_match check failed");

`endif

// File: hdl/sfm_pkg.sv
`timescale 1ns / 1ps

package sfm_pkg;

   localparam int MAX_NEEDLE     = 16;
   localparam int POS_BITS       = 16;
   localparam int WIN_DEPTH      = MAX_NEEDLE - 1;
   localparam int LEN_BITS       = 5;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam int MATCH_POS_BITS = 16;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_NEEDLE_LEN  = 2'd0,
      CSR_NEEDLE_LOW  = 2'd1,
      CSR_NEEDLE_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_SEARCH    = 2'd0,
      ST_MATCH     = 2'd1,
      ST_END_NONE  = 2'd2,
      ST_END_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   // Pick needle byte k out of the two 64-bit needle words.
   function automatic logic [7:0] needle_byte(input logic [63:0] low_word,
                                              input logic [63:0] high_word,
                                              input logic [3:0]  k);
      logic [7:0] sel;
      if (k[3]) begin
         sel = high_word[8*k[2:0] +: 8];
      end else begin
         sel = low_word[8*k[2:0] +: 8];
      end
      return sel;
   endfunction

endpackage

// File: hdl/substring_first_match.sv
`timescale 1ns / 1ps
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while req_stall is low; the window compare over all cells is combinational.
// req_stall rises only while a result is held and rsp_stall is high.
// Reset (synchronous, active high) clears the needle registers, the window,
// the byte counter and the match state, and empties the output register.

module substring_first_match import sfm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_hay_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [MATCH_POS_BITS-1:0] rsp_match_pos
);

   logic [LEN_BITS-1:0]       needle_len_ff;
   logic [63:0]               needle_low_ff;
   logic [63:0]               needle_high_ff;
   logic [POS_BITS-1:0]       count_ff, count_in;
   logic                      found_ff, found_in;
   logic [POS_BITS-1:0]       found_pos_ff, found_pos_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [MATCH_POS_BITS-1:0] rsp_match_pos_ff, rsp_match_pos_in;

   logic                      accept;
   logic [LEN_BITS-1:0]       len_c;
   logic [LEN_BITS-1:0]       len_m1;
   logic [POS_BITS:0]         count_p1;
   logic                      empty_first;
   logic                      terminator;
   logic                      full_match;
   logic [POS_BITS-1:0]       start_pos;
   cell_ctl_type              ctl;

   logic [7:0]                win [WIN_DEPTH];
   logic [7:0]                pos_needle [MAX_NEEDLE];
   logic [MAX_NEEDLE-1:0]     pos_active;
   logic [MAX_NEEDLE-1:0]     pos_eq;

   function automatic logic [MATCH_POS_BITS-1:0] to_match_pos(input logic [POS_BITS-1:0] p);
      logic [31:0] w;
      w = 32'(p);
      return w[MATCH_POS_BITS-1:0];
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_len_ff  <= '0;
         needle_low_ff  <= '0;
         needle_high_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NEEDLE_LEN:  needle_len_ff  <= csr_wdata[LEN_BITS-1:0];
            CSR_NEEDLE_LOW:  needle_low_ff  <= csr_wdata;
            CSR_NEEDLE_HIGH: needle_high_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   assign len_c  = (needle_len_ff > LEN_BITS'(MAX_NEEDLE)) ? LEN_BITS'(MAX_NEEDLE)
                                                          : needle_len_ff;
   assign len_m1 = len_c - LEN_BITS'(1);

   // Position p is the current byte (p = 0) or window entry p-1; it lines up
   // with needle byte len-1-p.
   for (genvar p = 0; p < MAX_NEEDLE; p++) begin : g_pos
      logic [LEN_BITS-1:0] kidx;
      assign kidx           = len_m1 - LEN_BITS'(p);
      assign pos_active[p]  = len_c > LEN_BITS'(p);
      assign pos_needle[p]  = needle_byte(needle_low_ff, needle_high_ff, kidx[3:0]);
   end

   assign pos_eq[0] = !pos_active[0] || (req_hay_byte == pos_needle[0]);

   for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
      sfm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .shift_data  ((j == 0) ? req_hay_byte : win[(j == 0) ? 0 : j-1]),
         .needle_data (pos_needle[j+1]),
         .active      (pos_active[j+1]),
         .data_out    (win[j]),
         .eq          (pos_eq[j+1])
      );
   end

   assign accept      = req_valid && !req_stall;
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign terminator  = (req_hay_byte == 8'd0);
   assign empty_first = !found_ff && (len_c == '0) && (count_ff == '0);
   assign count_p1    = {1'b0, count_ff} + {{POS_BITS{1'b0}}, 1'b1};
   assign full_match  = (len_c != '0) && (count_p1 >= (POS_BITS+1)'(len_c)) && (&pos_eq);
   assign start_pos   = count_ff - POS_BITS'(len_m1);

   always_comb begin
      count_in         = count_ff;
      found_in         = found_ff;
      found_pos_in     = found_pos_ff;
      ctl              = '0;
      rsp_status_in    = ST_SEARCH;
      rsp_match_pos_in = '0;
      if (accept) begin
         if (empty_first && !terminator) begin
            found_in      = 1'b1;
            found_pos_in  = '0;
            rsp_status_in = ST_MATCH;
         end else if (terminator) begin
            if (found_ff || empty_first) begin
               rsp_status_in    = ST_END_FOUND;
               rsp_match_pos_in = empty_first ? '0 : to_match_pos(found_pos_ff);
            end else begin
               rsp_status_in = ST_END_NONE;
            end
            // Rearm for the next haystack.
            count_in     = '0;
            found_in     = 1'b0;
            found_pos_in = '0;
            ctl.clear    = 1'b1;
         end else if (!found_ff) begin
            if (full_match) begin
               found_in         = 1'b1;
               found_pos_in     = start_pos;
               rsp_status_in    = ST_MATCH;
               rsp_match_pos_in = to_match_pos(start_pos);
            end else begin
               ctl.shift = 1'b1;
               if (count_ff != {POS_BITS{1'b1}}) begin
                  count_in = count_p1[POS_BITS-1:0];
               end
            end
         end
      end
   end

   // Hold the result while the consumer stalls; refill on each accepted item.
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         found_ff     <= 1'b0;
         found_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         found_ff     <= found_in;
         found_pos_ff <= found_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_match_pos_ff <= rsp_match_pos_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_match_pos = rsp_match_pos_ff;

endmodule

// File: hdl/sfm_cell.sv
`timescale 1ns / 1ps

module sfm_cell import sfm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic [7:0]   shift_data,
   input  logic [7:0]   needle_data,
   input  logic         active,
   output logic [7:0]   data_out,
   output logic         eq
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.clear) begin
         data_in = '0;
      end else if (ctl.shift) begin
         data_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;
   // Positions beyond the needle length never block a match.
   assign eq = !active || (data_ff == needle_data);

endmodule

// File: hdl/sfm_checker.sv
`timescale 1ns / 1ps
`include "substring_first_match_assert.svh"

module sfm_checker import sfm_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [1:0]                rsp_status,
   input logic [MATCH_POS_BITS-1:0] rsp_match_pos
);

   `SFM_ASSERT_NEXT(a_accept_gives_result, req_valid && !req_stall, rsp_valid)
   `SFM_ASSERT_NOW(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall)
   `SFM_ASSERT_NOW(a_pos_zero_without_match, rsp_valid && (rsp_status == ST_SEARCH || rsp_status == ST_END_NONE), rsp_match_pos == '0)
   `SFM_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && rsp_stall, rsp_valid)
   `SFM_ASSERT_NEXT(a_rsp_payload_holds, rsp_valid && rsp_stall, $stable(rsp_status) && $stable(rsp_match_pos))

endmodule

bind substring_first_match sfm_checker u_sfm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_match_pos (rsp_match_pos)
);

// File: verif/substring_first_match_test.sv
`timescale 1ns / 1ps

import sfm_pkg::*;

typedef struct packed {
   status_type  status;
   logic [15:0] pos;
} hay_result_type;

class match_scoreboard;
   logic [4:0]  len_reg;
   logic [63:0] low_word;
   logic [63:0] high_word;
   logic [7:0]  window [WIN_DEPTH];
   logic [15:0] byte_idx;
   bit          found;
   logic [15:0] found_at;
   hay_result_type expected_results [$];
   int          failures;
   int          reported;
   int          checked;
   int          first_hits;
   int          ends_found;
   int          ends_none;

   function new();
      len_reg    = 5'd0;
      low_word   = 64'h0;
      high_word  = 64'h0;
      failures   = 0;
      reported   = 0;
      checked    = 0;
      first_hits = 0;
      ends_found = 0;
      ends_none  = 0;
      rearm();
   endfunction

   function void rearm();
      foreach (window[i]) window[i] = 8'h00;
      byte_idx = 16'h0;
      found    = 1'b0;
      found_at = 16'h0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [63:0] data);
      if (idx == CSR_NEEDLE_LEN) begin
         len_reg = data[4:0];
      end else if (idx == CSR_NEEDLE_LOW) begin
         low_word = data;
      end else if (idx == CSR_NEEDLE_HIGH) begin
         high_word = data;
      end
   endfunction

   function logic [7:0] pattern_byte(int k);
      if (k < 8) begin
         return low_word[8*k +: 8];
      end
      return high_word[8*(k-8) +: 8];
   endfunction

   function void push_result(status_type st, logic [15:0] pos);
      hay_result_type r;
      r.status = st;
      r.pos    = pos;
      expected_results.push_back(r);
      if (st == ST_MATCH) first_hits++;
      if (st == ST_END_FOUND) ends_found++;
      if (st == ST_END_NONE) ends_none++;
   endfunction

   function void note_hay_byte(logic [7:0] b);
      int         n;
      bit         hit;
      int         back;
      logic [7:0] h;
      n = (len_reg > MAX_NEEDLE) ? MAX_NEEDLE : int'(len_reg);
      // empty needle matches at the first byte of each haystack
      if (!found && n == 0 && byte_idx == 16'h0) begin
         found    = 1'b1;
         found_at = 16'h0;
         if (b != 8'h00) begin
            push_result(ST_MATCH, 16'h0);
            return;
         end
      end
      if (b == 8'h00) begin
         push_result(found ? ST_END_FOUND : ST_END_NONE, found ? found_at : 16'h0);
         rearm();
         return;
      end
      // drop everything after the first match
      if (found) begin
         push_result(ST_SEARCH, 16'h0);
         return;
      end
      if (n > 0 && int'(byte_idx) + 1 >= n) begin
         hit = 1'b1;
         for (int k = 0; k < n; k++) begin
            back = n - 1 - k;
            h = (back == 0) ? b : window[back-1];
            if (h != pattern_byte(k)) hit = 1'b0;
         end
         if (hit) begin
            found    = 1'b1;
            found_at = byte_idx - 16'(n - 1);
            push_result(ST_MATCH, found_at);
            return;
         end
      end
      for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (byte_idx != 16'hFFFF) byte_idx++;
      push_result(ST_SEARCH, 16'h0);
   endfunction

   function void check_result(logic [1:0] st, logic [15:0] pos);
      hay_result_type want;
      checked++;
      if (expected_results.size() == 0) begin
         failures++;
         if (reported < 10) begin
            reported++;
            $display("unexpected result %0d: status %0d match_pos %0d", checked, st, pos);
         end
         return;
      end
      want = expected_results.pop_front();
      if (st !== want.status || pos !== want.pos) begin
         failures++;
         if (reported < 10) begin
            reported++;
            $display("result %0d: expected status %0d match_pos %0d, got status %0d match_pos %0d",
                     checked, want.status, want.pos, st, pos);
         end
      end
   endfunction

   function void close_out();
      if (expected_results.size() != 0) begin
         failures += expected_results.size();
         $display("%0d expected results never arrived", expected_results.size());
      end
   endfunction
endclass

module substring_first_match_test;

   typedef enum int {ALPHA_AB, ALPHA_ABCD, ALPHA_FULL} alpha_mode_type;

   localparam logic [1:0] CSR_SPARE   = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         RANDOM_ITEMS = 900;
   localparam int         LONG_BYTES  = 200;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   logic                      req_valid;
   logic                      req_stall;
   logic [7:0]                req_hay_byte;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_status;
   logic [MATCH_POS_BITS-1:0] rsp_match_pos;

   match_scoreboard sb = new();

   logic [7:0] needle_q [MAX_NEEDLE];
   logic [7:0] hay_q [$];
   bit         idling = 1'b1;
   int         items_sent = 0;
   int         settings_used = 0;
   int         cycle_count = 0;

   substring_first_match uut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_hay_byte  (req_hay_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_match_pos (rsp_match_pos)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("substring_first_match: mismatch");
      $finish;
   end

   // result side: random stall while idling, check at the rising edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_status, rsp_match_pos);
         end
         @(negedge clock);
         rsp_stall = idling && ($urandom_range(0, 99) < 17);
      end
   end

   function automatic logic [7:0] rand_byte(alpha_mode_type mode);
      case (mode)
         ALPHA_AB:   return 8'h61 + 8'($urandom_range(0, 1));
         ALPHA_ABCD: return 8'h61 + 8'($urandom_range(0, 3));
         default:    return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [63:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic load_needle(logic [63:0] len_word);
      logic [63:0] lo;
      logic [63:0] hi;
      for (int k = 0; k < 8; k++) begin
         lo[8*k +: 8] = needle_q[k];
         hi[8*k +: 8] = needle_q[k+8];
      end
      csr_write(CSR_NEEDLE_LEN, len_word);
      csr_write(CSR_NEEDLE_LOW, lo);
      csr_write(CSR_NEEDLE_HIGH, hi);
      settings_used++;
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(logic [7:0] b);
      while (idling && $urandom_range(0, 99) < 17) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_hay_byte = b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_hay_byte(b);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_haystack();
      foreach (hay_q[i]) send_byte(hay_q[i]);
      send_byte(8'h00);
   endtask

   // hold off the sender until every result is back
   task automatic drain();
      req_valid = 1'b0;
      while (sb.expected_results.size() != 0) @(negedge clock);
   endtask

   initial begin
      int             base_items;
      int             len_val;
      int             eff;
      int             kind;
      int             cut;
      int             prefix;
      alpha_mode_type mode;
      logic [63:0]    len_word;

      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_valid    = 1'b0;
      req_hay_byte = 8'h00;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // empty needle from reset, terminator first, then extremes
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'h00);
      drain();

      foreach (needle_q[k]) needle_q[k] = 8'hFF;
      needle_q[0] = 8'h61;
      needle_q[1] = 8'h62;
      needle_q[2] = 8'h63;
      load_needle(64'd3);
      hay_q = '{8'h78, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62};
      send_haystack();
      drain();

      // zero leading needle byte: the cleared window must not match it
      foreach (needle_q[k]) needle_q[k] = 8'h00;
      needle_q[1] = 8'h62;
      load_needle(64'd2);
      csr_write(CSR_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
      hay_q = '{8'h62, 8'h80, 8'h00, 8'h62};
      send_haystack();
      drain();

      // long haystack without idling, needle followed by three random bytes at its end
      idling = 1'b0;
      foreach (needle_q[k]) needle_q[k] = 8'h00;
      needle_q[0] = 8'hF1;
      needle_q[1] = 8'hF2;
      needle_q[2] = 8'hF3;
      needle_q[3] = 8'hF4;
      load_needle(64'd4);
      hay_q.delete();
      repeat (LONG_BYTES) hay_q.push_back(8'($urandom_range(1, 8'hF0)));
      for (int k = 0; k < 4; k++) hay_q.push_back(needle_q[k]);
      repeat (3) hay_q.push_back(8'($urandom_range(1, 255)));
      send_haystack();
      drain();
      idling = 1'b1;

      base_items = items_sent;
      while (items_sent - base_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 6) len_val = 0;
         else if (kind < 14) len_val = MAX_NEEDLE;
         else if (kind < 20) len_val = $urandom_range(MAX_NEEDLE + 1, 31);
         else len_val = $urandom_range(1, MAX_NEEDLE - 1);
         eff  = (len_val > MAX_NEEDLE) ? MAX_NEEDLE : len_val;
         mode = alpha_mode_type'($urandom_range(0, 2));
         foreach (needle_q[k]) needle_q[k] = rand_byte(mode);
         if ($urandom_range(0, 19) == 0) begin
            foreach (needle_q[k]) needle_q[k] = 8'hFF;
         end
         if (eff > 0 && $urandom_range(0, 9) == 0) begin
            needle_q[$urandom_range(0, eff - 1)] = 8'h00;
         end
         len_word = 64'(len_val);
         if ($urandom_range(0, 3) == 0) begin
            len_word = ({$urandom, $urandom} & ~64'h1F) | 64'(len_val);
         end
         load_needle(len_word);

         repeat ($urandom_range(2, 6)) begin
            hay_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
               prefix = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(0, 10);
               repeat (prefix) hay_q.push_back(rand_byte(mode));
               // broken sequences stop short of the full needle
               if (kind < 70) cut = eff;
               else cut = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
               for (int k = 0; k < cut; k++) hay_q.push_back(needle_q[k]);
               repeat ($urandom_range(0, 6)) hay_q.push_back(rand_byte(mode));
            end else begin
               repeat ($urandom_range(0, 30)) hay_q.push_back(rand_byte(ALPHA_FULL));
            end
            send_haystack();
         end
         drain();
      end

      repeat (10) @(negedge clock);
      sb.close_out();
      $display("sent %0d haystack bytes over %0d needle settings, %0d results checked",
               items_sent, settings_used, sb.checked);
      $display("first matches %0d, ends after a match %0d, ends without a match %0d",
               sb.first_hits, sb.ends_found, sb.ends_none);
      if (sb.failures == 0) begin
         $display("substring_first_match: match");
      end else begin
         $display("substring_first_match: mismatch");
      end
      $finish;
   end

endmodule

// File: substring_first_match.f
+incdir+hdl
hdl/sfm_pkg.sv
hdl/sfm_cell.sv
hdl/substring_first_match.sv
hdl/sfm_checker.sv
verif/substring_first_match_test.sv
